FILE: rtl/msp_v2_frame_parser_macros.svh
// Assertion macros used by the checker of the frame parser.
// Expects clk and rst in the scope of use.
`ifndef MSP_V2_FRAME_PARSER_MACROS_SVH
`define MSP_V2_FRAME_PARSER_MACROS_SVH

// Concurrent check, same-cycle implication inside prop.
`define MSPV2_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check, consequence in the cycle after the antecedent.
`define MSPV2_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mspv2_pkg.sv
// Package of the frame parser: types, codes, constants and the CRC-8 byte step.
// Used by the front end, back end and top level of the block and by its checker.
package mspv2_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int CFG_INDEX_W     = 1;
  localparam int CFG_DATA_W      = 16;

  localparam logic [15:0] MAX_SIZE_RST = 16'd256;
  localparam logic [15:0] TIMEOUT_RST  = 16'd1000;
  localparam logic [7:0]  CRC_POLY     = 8'hD5;
  localparam logic [7:0]  CHAR_DOLLAR  = 8'h24;
  localparam logic [7:0]  CHAR_X       = 8'h58;
  localparam logic [7:0]  CHAR_GT      = 8'h3E;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MAX_SIZE = 1'b0,
    REG_TIMEOUT  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_OK      = 2'd1,
    KIND_CRC_ERR = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PH_HUNT  = 4'd0,
    PH_X     = 4'd1,
    PH_GT    = 4'd2,
    PH_FLAG  = 4'd3,
    PH_ID_LO = 4'd4,
    PH_ID_HI = 4'd5,
    PH_SZ_LO = 4'd6,
    PH_SZ_HI = 4'd7,
    PH_DATA  = 4'd8,
    PH_CRC   = 4'd9
  } phase_t;

  // Classified item as it sits in the queue.
  typedef struct packed {
    logic       tick;
    logic [7:0] data;
    logic       is_dollar;
    logic       is_x;
    logic       is_gt;
  } token_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/mspv2_ifs.sv
// Valid/ready channel interfaces of the frame parser: input items and results.
// No dependencies.
interface mspv2_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source(output valid, command, rx_byte, input ready);
  modport sink(input valid, command, rx_byte, output ready);
endinterface

interface mspv2_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;
  logic        store_enable;
  logic [15:0] message_id;
  logic [15:0] payload_size;
  logic [15:0] stored_count;
  logic [7:0]  crc_computed;

  modport source(output valid, result_kind, data_byte, byte_index, store_enable, message_id,
                 payload_size, stored_count, crc_computed, input ready);
  modport sink(input valid, result_kind, data_byte, byte_index, store_enable, message_id,
               payload_size, stored_count, crc_computed, output ready);
endinterface

FILE: rtl/mspv2_front.sv
// Front end: accepts items, classifies header characters, queues tokens.
// Depends on mspv2_pkg and mspv2_in_if.
module mspv2_front #(
  parameter int DEPTH = mspv2_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  mspv2_in_if.sink            items,
  output mspv2_pkg::token_t   head,
  output logic                head_valid,
  input  logic                pop
);
  import mspv2_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  token_t             queue_mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic               push;
  token_t             token_in;

  assign items.ready = (count != FULL);
  assign push        = items.valid && items.ready;
  assign head        = queue_mem[rd_ptr];
  assign head_valid  = (count != '0);

  always_comb begin
    token_in.tick      = (items.command == CMD_TICK);
    token_in.data      = items.rx_byte;
    token_in.is_dollar = (items.rx_byte == CHAR_DOLLAR);
    token_in.is_x      = (items.rx_byte == CHAR_X);
    token_in.is_gt     = (items.rx_byte == CHAR_GT);
  end

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + 1'b1;
      2'b01:   count_next = count - 1'b1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_ptr] <= token_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

endmodule

FILE: rtl/mspv2_back.sv
// Back end: frame state machine, CRC-8, frame timer, config registers, result register.
// Depends on mspv2_pkg and mspv2_out_if.
module mspv2_back #(
  parameter int TIMER_WIDTH = mspv2_pkg::TIMER_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  mspv2_pkg::token_t                     head,
  input  logic                                  head_valid,
  output logic                                  pop,
  input  logic                                  cfg_we,
  input  logic [mspv2_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mspv2_pkg::CFG_DATA_W-1:0]      cfg_data,
  mspv2_out_if.source                           results
);
  import mspv2_pkg::*;

  localparam int CMP_W = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  logic [15:0]            max_size;
  logic [15:0]            timeout_ticks;

  phase_t                 phase, phase_next;
  logic [7:0]             crc_value, crc_value_next;
  logic [15:0]            id_value, id_value_next;
  logic [15:0]            size_value, size_value_next;
  logic [15:0]            payload_counter, payload_counter_next;
  logic [TIMER_WIDTH-1:0] frame_timer, frame_timer_next;

  logic [7:0]             crc_upd;
  logic [TIMER_WIDTH-1:0] timer_sat;
  logic                   timer_hit;
  logic                   idx_last;
  logic [15:0]            size_hi_done;

  logic                   emit;
  kind_t                  kind;
  logic [7:0]             data_out;
  logic [15:0]            index_out;
  logic                   store_out;
  logic [15:0]            stored_out;

  logic                   res_valid;
  kind_t                  res_kind;
  logic [7:0]             res_data;
  logic [15:0]            res_index;
  logic                   res_store;
  logic [15:0]            res_id;
  logic [15:0]            res_size;
  logic [15:0]            res_stored;
  logic [7:0]             res_crc;

  assign pop = head_valid && (!res_valid || results.ready);

  assign crc_upd      = crc8_step((phase == PH_FLAG) ? 8'h00 : crc_value, head.data);
  assign timer_sat    = (frame_timer == '1) ? frame_timer : frame_timer + 1'b1;
  assign timer_hit    = (CMP_W'(timer_sat) >= CMP_W'(timeout_ticks));
  assign idx_last     = (({1'b0, payload_counter} + 17'd1) >= {1'b0, size_value});
  assign size_hi_done = {head.data, size_value[7:0]};

  // next state
  always_comb begin
    phase_next           = phase;
    crc_value_next       = crc_value;
    id_value_next        = id_value;
    size_value_next      = size_value;
    payload_counter_next = payload_counter;
    frame_timer_next     = frame_timer;
    if (head.tick) begin
      if (phase != PH_HUNT) begin
        if (timer_hit) begin
          phase_next       = PH_HUNT;
          frame_timer_next = '0;
        end else begin
          frame_timer_next = timer_sat;
        end
      end
    end else begin
      case (phase)
        PH_HUNT: begin
          if (head.is_dollar) begin
            phase_next       = PH_X;
            frame_timer_next = '0;
          end
        end
        PH_X:  phase_next = head.is_x ? PH_GT : PH_HUNT;
        PH_GT: phase_next = head.is_gt ? PH_FLAG : PH_HUNT;
        PH_FLAG: begin
          crc_value_next       = crc_upd;
          id_value_next        = '0;
          size_value_next      = '0;
          payload_counter_next = '0;
          phase_next           = PH_ID_LO;
        end
        PH_ID_LO: begin
          crc_value_next = crc_upd;
          id_value_next  = {8'h00, head.data};
          phase_next     = PH_ID_HI;
        end
        PH_ID_HI: begin
          crc_value_next = crc_upd;
          id_value_next  = {head.data, id_value[7:0]};
          phase_next     = PH_SZ_LO;
        end
        PH_SZ_LO: begin
          crc_value_next  = crc_upd;
          size_value_next = {8'h00, head.data};
          phase_next      = PH_SZ_HI;
        end
        PH_SZ_HI: begin
          crc_value_next       = crc_upd;
          size_value_next      = size_hi_done;
          payload_counter_next = '0;
          phase_next           = (size_hi_done != '0) ? PH_DATA : PH_CRC;
        end
        PH_DATA: begin
          crc_value_next       = crc_upd;
          payload_counter_next = payload_counter + 1'b1;
          if (idx_last) begin
            phase_next = PH_CRC;
          end
        end
        PH_CRC: begin
          phase_next       = PH_HUNT;
          frame_timer_next = '0;
        end
        default: phase_next = PH_HUNT;
      endcase
    end
  end

  // result
  always_comb begin
    emit      = 1'b0;
    kind      = KIND_DATA;
    data_out  = '0;
    index_out = '0;
    store_out = 1'b0;
    if (head.tick) begin
      emit = (phase != PH_HUNT) && timer_hit;
      kind = KIND_TIMEOUT;
    end else begin
      case (phase)
        PH_DATA: begin
          emit      = 1'b1;
          kind      = KIND_DATA;
          data_out  = head.data;
          index_out = payload_counter;
          store_out = (payload_counter < max_size);
        end
        PH_CRC: begin
          emit = 1'b1;
          kind = (head.data == crc_value) ? KIND_OK : KIND_CRC_ERR;
        end
        default: emit = 1'b0;
      endcase
    end
    stored_out = (size_value_next < max_size) ? size_value_next : max_size;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_size        <= MAX_SIZE_RST;
      timeout_ticks   <= TIMEOUT_RST;
      phase           <= PH_HUNT;
      crc_value       <= '0;
      id_value        <= '0;
      size_value      <= '0;
      payload_counter <= '0;
      frame_timer     <= '0;
      res_valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_SIZE: max_size      <= cfg_data;
          REG_TIMEOUT:  timeout_ticks <= cfg_data;
          default:      max_size      <= max_size;
        endcase
      end
      if (pop) begin
        phase           <= phase_next;
        crc_value       <= crc_value_next;
        id_value        <= id_value_next;
        size_value      <= size_value_next;
        payload_counter <= payload_counter_next;
        frame_timer     <= frame_timer_next;
        res_valid       <= emit;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      res_kind   <= kind;
      res_data   <= data_out;
      res_index  <= index_out;
      res_store  <= store_out;
      res_id     <= id_value_next;
      res_size   <= size_value_next;
      res_stored <= stored_out;
      res_crc    <= crc_value_next;
    end
  end

  assign results.valid        = res_valid;
  assign results.result_kind  = res_kind;
  assign results.data_byte    = res_data;
  assign results.byte_index   = res_index;
  assign results.store_enable = res_store;
  assign results.message_id   = res_id;
  assign results.payload_size = res_size;
  assign results.stored_count = res_stored;
  assign results.crc_computed = res_crc;

endmodule

FILE: rtl/msp_v2_frame_parser.sv
// Path of an item: the edge that accepts it writes its token into the token queue; the edge
// that pops the token from the queue head steps the parser into the result register.
// Throughput: one item per cycle unless results stall, set by the parser step and CRC update.
// Reset (rst, synchronous): empties the queue, parser hunts for '$', max_size = 256,
// timeout_ticks = 1000; no clearing pass.
module msp_v2_frame_parser #(
  parameter int TIMER_WIDTH = mspv2_pkg::TIMER_WIDTH_DEF,
  parameter int QUEUE_DEPTH = mspv2_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  mspv2_in_if.sink                          items,
  mspv2_out_if.source                       results,
  input  logic                              cfg_we,
  input  logic [mspv2_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mspv2_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mspv2_pkg::*;

  token_t head;
  logic   head_valid;
  logic   pop;

  mspv2_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop)
  );

  mspv2_back #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .results   (results)
  );

endmodule

FILE: rtl/mspv2_checker.sv
// Port-level checks on the parser's result channel, bound to the top level.
// Depends on mspv2_pkg and msp_v2_frame_parser_macros.svh.
`include "msp_v2_frame_parser_macros.svh"

module mspv2_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  res_kind,
  input logic [7:0]  res_data,
  input logic [15:0] res_index,
  input logic        res_store,
  input logic [15:0] res_size,
  input logic [15:0] res_stored
);
  import mspv2_pkg::*;

  `MSPV2_ASSERT(a_end_fields_zero, res_valid && (res_kind != KIND_DATA) |-> (res_data == 8'h00) && (res_index == 16'h0000) && !res_store, "frame end result carries payload fields")
  `MSPV2_ASSERT(a_stored_le_size, res_valid |-> (res_stored <= res_size), "stored_count above payload_size")
  `MSPV2_ASSERT(a_data_index, res_valid && (res_kind == KIND_DATA) |-> (res_index < res_size) && (res_store == (res_index < res_stored)), "payload index or store flag inconsistent")
  `MSPV2_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_kind) && $stable(res_index), "stalled result dropped or changed")

endmodule

bind msp_v2_frame_parser mspv2_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_kind  (results.result_kind),
  .res_data  (results.data_byte),
  .res_index (results.byte_index),
  .res_store (results.store_enable),
  .res_size  (results.payload_size),
  .res_stored(results.stored_count)
);
